@@ rtl/snssf_pkg.sv @@
`timescale 1ns / 1ps
package snssf_pkg;

    localparam logic [7:0] SEG_MINUS  = 8'h40;
    localparam logic [7:0] SEG_DOT    = 8'h80;
    localparam logic [7:0] FRAME_ADDR = 8'h08;
    localparam logic [7:0] FRAME_CMD  = 8'h18;
    localparam logic [7:0] FRAME_CTRL = 8'h12;

    // mag / 10 == (mag * 52429) >> 19 for mag < 81920
    localparam logic [16:0] RECIP_TEN  = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        FUNC_SHOW    = 3'd0,
        FUNC_SET     = 3'd1,
        FUNC_DOT     = 3'd2,
        FUNC_CLEAR   = 3'd3,
        FUNC_DISPLAY = 3'd4
    } func_t;

    typedef struct packed {
        logic accept;
        logic render_step;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic zero_blank;
        logic render_done;
        logic emit_done;
        logic out_free;
    } status_t;

    function automatic logic [7:0] hex_seg(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/snssf_ctrl.sv @@
`timescale 1ns / 1ps
module snssf_ctrl
    import snssf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  status_t    status,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RENDER = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.accept      = 1'b0;
        cmd.render_step = 1'b0;
        cmd.emit_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (func == FUNC_SHOW && !status.zero_blank)
                    begin
                        state_next = ST_RENDER;
                    end
                    else if (func == FUNC_DISPLAY)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RENDER:
            begin
                cmd.render_step = 1'b1;
                if (status.render_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/snssf_datapath.sv @@
`timescale 1ns / 1ps
module snssf_datapath
    import snssf_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic [2:0]         func,
    input  logic signed [15:0] number,
    input  logic [2:0]         position,
    input  logic [7:0]         segments,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_byte,
    output logic               last
);

    localparam int PW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int FRAME_N  = DIGITS + 3;
    localparam int IW       = $clog2(FRAME_N);
    localparam logic [IW-1:0] IDX_LAST = IW'(FRAME_N - 1);
    localparam logic [PW-1:0] POS_FIRST = PW'(DIGITS - 1);

    logic [7:0]    buf_reg [DIGITS];
    logic [7:0]    buf_next [DIGITS];
    logic          lz_reg;
    logic [16:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    frame_byte_reg, frame_byte_next;
    logic          last_reg, last_next;

    logic          in_neg;
    logic [16:0]   in_mag;
    logic [33:0]   prod;
    logic [16:0]   quot;
    logic [16:0]   rem_full;
    logic [3:0]    digit;
    logic          spent;
    logic [7:0]    render_seg;
    logic [7:0]    emit_byte;

    assign in_neg = number[15];
    assign in_mag = in_neg ? (17'd0 - {number[15], number}) : {1'b0, number};

    assign prod     = mag_reg * RECIP_TEN;
    assign quot     = 17'(prod >> RECIP_SHIFT);
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));
    assign digit    = rem_full[3:0];
    assign spent    = (mag_reg == 17'd0);

    always_comb
    begin
        if (spent && neg_reg)
        begin
            render_seg = SEG_MINUS;
        end
        else if (spent && !lz_reg)
        begin
            render_seg = 8'h00;
        end
        else
        begin
            render_seg = hex_seg(digit);
        end
    end

    always_comb
    begin
        emit_byte = FRAME_ADDR;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (idx_reg == IW'(i + 1))
            begin
                emit_byte = buf_reg[i];
            end
        end
        if (idx_reg == IW'(DIGITS + 1))
        begin
            emit_byte = FRAME_CMD;
        end
        else if (idx_reg == IDX_LAST)
        begin
            emit_byte = FRAME_CTRL;
        end
    end

    always_comb
    begin
        status.zero_blank  = (number == 16'sd0) && !lz_reg;
        status.render_done = (pos_reg == '0);
        status.emit_done   = (idx_reg == IDX_LAST);
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        buf_next        = buf_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        frame_byte_next = frame_byte_reg;
        last_next       = last_reg;

        if (cmd.accept)
        begin
            unique case (func)
                FUNC_SHOW:
                begin
                    if (status.zero_blank)
                    begin
                        for (int i = 0; i < DIGITS; i++)
                        begin
                            buf_next[i] = 8'h00;
                        end
                        buf_next[DIGITS-1] = hex_seg(4'h0);
                    end
                    else
                    begin
                        mag_next = in_mag;
                        neg_next = in_neg;
                        pos_next = POS_FIRST;
                    end
                end
                FUNC_SET:
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if (position == 3'(i + 1))
                        begin
                            buf_next[i] = segments;
                        end
                    end
                end
                FUNC_DOT:
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if (position == 3'(i + 1))
                        begin
                            buf_next[i] = buf_reg[i] | SEG_DOT;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        buf_next[i] = 8'h00;
                    end
                end
                FUNC_DISPLAY:
                begin
                    idx_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.render_step)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                if (pos_reg == PW'(i))
                begin
                    buf_next[i] = render_seg;
                end
            end
            if (spent)
            begin
                neg_next = 1'b0;
            end
            mag_next = quot;
            pos_next = pos_reg - PW'(1);
        end

        if (cmd.emit_load)
        begin
            out_valid_next  = 1'b1;
            frame_byte_next = emit_byte;
            last_next       = (idx_reg == IDX_LAST);
            idx_next        = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                buf_reg[i] <= 8'h00;
            end
            lz_reg        <= 1'b0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            neg_reg       <= neg_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                lz_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        frame_byte_reg <= frame_byte_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last       = last_reg;

endmodule

@@ rtl/signed_number_seven_segment_frame_unit.sv @@
// Set digit, set dot and clear write the digit buffer on accept, as does show number for a blanked zero;
// other numbers are rendered one decimal digit per cycle from the divide-by-ten step.
// Display: a frame of DIGITS + 3 bytes, registered and sent one per cycle while out_ready
// holds; the first byte is the address byte and the last the control byte.
// Throughput: one item at a time; in_ready drops while rendering or emitting a frame.
// Reset (rst_n, async, active low): digit buffer blank, leading_zero 0, output empty.
`timescale 1ns / 1ps
module signed_number_seven_segment_frame_unit
    import snssf_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [15:0] number,
    input  logic [2:0]         position,
    input  logic [7:0]         segments,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_byte,
    output logic               last
);

    cmd_t    cmd;
    status_t status;

    snssf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    snssf_datapath #(
        .DIGITS (DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .func       (func),
        .number     (number),
        .position   (position),
        .segments   (segments),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last       (last)
    );

endmodule

@@ rtl/snssf_checker.sv @@
`timescale 1ns / 1ps
module snssf_checker
    import snssf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last))
        else $error("stalled output item changed");

    a_last_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_byte == FRAME_CTRL)
        else $error("last byte is not the control byte");

    // a frame whose first byte directly follows the last byte of the one before opens with the address byte
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid || frame_byte == FRAME_ADDR)
        else $error("frame does not start with address byte");

    // no input taken mid-frame
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input accepted during frame emission");

endmodule

bind signed_number_seven_segment_frame_unit snssf_checker u_snssf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last       (last)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import snssf_pkg::*;

    localparam int NUM_DIGITS = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 49;
    localparam int NUM_PHASES = 8;
    localparam bit LZ_PLAN [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1};
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam logic [2:0] POS_NONE = 3'd0;
    localparam logic [2:0] POS_TOP = 3'd7;
    localparam logic [7:0] DIGIT_FONT [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } frame_entry_t;

    class segment_frame_tracker;
        logic [7:0]   digit_buf [NUM_DIGITS];
        bit           leading_zero;
        frame_entry_t pending_bytes [$];
        int           errors;
        int           items;
        int           frames;
        int           bytes_checked;

        function new();
            foreach (digit_buf[i])
                digit_buf[i] = '0;
            leading_zero = 1'b0;
        endfunction

        function void render_value(logic signed [15:0] value);
            int mag;
            int d;
            bit neg;
            bit spent;
            neg = value[15];
            mag = neg ? -int'(value) : int'(value);
            if (mag == 0 && !leading_zero)
            begin
                foreach (digit_buf[i])
                    digit_buf[i] = '0;
                digit_buf[NUM_DIGITS - 1] = DIGIT_FONT[0];
                return;
            end
            for (int pos = NUM_DIGITS - 1; pos >= 0; pos--)
            begin
                d = mag % 10;
                spent = (d == 0 && mag == 0);
                digit_buf[pos] = (spent && !leading_zero) ? 8'h00 : DIGIT_FONT[d];
                if (spent && neg)
                begin
                    digit_buf[pos] = SEG_MINUS;
                    neg = 1'b0;
                end
                mag = mag / 10;
            end
        endfunction

        function void push_byte(logic [7:0] data, logic is_last);
            frame_entry_t e;
            e.data = data;
            e.is_last = is_last;
            pending_bytes.push_back(e);
        endfunction

        function void note_item(logic [2:0] f, logic signed [15:0] value,
                                logic [2:0] pos, logic [7:0] segs);
            bit pos_ok;
            pos_ok = (pos >= 1 && pos <= NUM_DIGITS);
            items++;
            case (f)
                FUNC_SHOW:
                    render_value(value);
                FUNC_SET:
                    if (pos_ok)
                        digit_buf[pos - 1] = segs;
                FUNC_DOT:
                    if (pos_ok)
                        digit_buf[pos - 1] = digit_buf[pos - 1] | SEG_DOT;
                FUNC_CLEAR:
                    foreach (digit_buf[i])
                        digit_buf[i] = '0;
                FUNC_DISPLAY:
                begin
                    frames++;
                    push_byte(FRAME_ADDR, 1'b0);
                    foreach (digit_buf[i])
                        push_byte(digit_buf[i], 1'b0);
                    push_byte(FRAME_CMD, 1'b0);
                    push_byte(FRAME_CTRL, 1'b1);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic is_last);
            frame_entry_t e;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected frame byte %02h last %0b", $time, data, is_last);
                errors++;
                return;
            end
            e = pending_bytes.pop_front();
            bytes_checked++;
            if (data !== e.data)
            begin
                $display("%0t: frame_byte expected %02h actual %02h", $time, e.data, data);
                errors++;
            end
            if (is_last !== e.is_last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         func = FUNC_CLEAR;
    logic signed [15:0] number = '0;
    logic [2:0]         position = '0;
    logic [7:0]         segments = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         frame_byte;
    logic               last;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycles = 0;

    segment_frame_tracker tracker = new();

    signed_number_seven_segment_frame_unit #(.DIGITS(NUM_DIGITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .number     (number),
        .position   (position),
        .segments   (segments),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_item(func, number, position, segments);
            if (out_valid && out_ready)
                tracker.check_byte(frame_byte, last);
        end
    end

    task automatic send_item(logic [2:0] f, logic signed [15:0] value,
                             logic [2:0] pos, logic [7:0] segs);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        number <= value;
        position <= pos;
        segments <= segs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_leading_zero(bit value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.leading_zero = value;
    endtask

    function automatic logic signed [15:0] pick_number();
        int v;
        case ($urandom_range(5))
            0: v = int'($urandom_range(40)) - 20;
            1: v = int'($urandom_range(19998)) - 9999;
            2:
            case ($urandom_range(7))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                3: v = 0;
                4: v = -1000;
                5: v = -999;
                6: v = 9999;
                default: v = 10000;
            endcase
            default: v = int'($urandom() & 32'hFFFF);
        endcase
        return 16'(v);
    endfunction

    task automatic send_random_item();
        int r;
        logic [2:0] f;
        logic [2:0] pos;
        r = $urandom_range(99);
        if (r < 30)
            f = FUNC_SHOW;
        else if (r < 45)
            f = FUNC_SET;
        else if (r < 57)
            f = FUNC_DOT;
        else if (r < 62)
            f = FUNC_CLEAR;
        else if (r < 94)
            f = FUNC_DISPLAY;
        else
            f = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        if ($urandom_range(9) == 0)
            pos = 3'($urandom_range(POS_TOP));
        else
            pos = 3'($urandom_range(NUM_DIGITS, 1));
        send_item(f, pick_number(), pos, 8'($urandom_range(255)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_leading_zero(1'b0);

        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SHOW, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SHOW, -16'sd32768, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SHOW, 16'sd32767, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SHOW, -16'sd7, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SHOW, -16'sd1000, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_SET, 16'sd0, POS_NONE, 8'hFF);
        send_item(FUNC_SET, 16'sd0, 3'(NUM_DIGITS + 1), 8'hFF);
        send_item(FUNC_SET, 16'sd0, POS_TOP, 8'hFF);
        send_item(FUNC_SET, 16'sd0, 3'd1, 8'hFF);
        send_item(FUNC_SET, 16'sd0, 3'(NUM_DIGITS), 8'h00);
        send_item(FUNC_DOT, 16'sd0, 3'd2, 8'h00);
        send_item(FUNC_DOT, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_DOT, 16'sd0, 3'(NUM_DIGITS + 1), 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);
        for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
            send_item(3'(f), -16'sd1, POS_TOP, 8'hFF);
        send_item(FUNC_CLEAR, 16'sd0, POS_NONE, 8'h00);
        send_item(FUNC_DISPLAY, 16'sd0, POS_NONE, 8'h00);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drain();
            set_leading_zero(LZ_PLAN[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
                default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_drain();
                send_random_item();
            end
        end

        wait_drain();
        $display("%0d items accepted, %0d frames, %0d frame bytes checked",
                 tracker.items, tracker.frames, tracker.bytes_checked);
        $display("both leading-zero settings, idling mixes from none to heavy on each side");
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
